### rtl/gld_pkg.sv
// Package: constants, types and status codes shared by the GIF LZW decoder.
package gld_pkg;
   localparam int MaxCodes    = 4096;
   localparam int MaxCodeBits = 12;
   localparam int AddrW       = 12;
   localparam logic [12:0] PrevNone = 13'h1fff;

   typedef enum logic [2:0] {
      ST_ACCEPT  = 3'd0,
      ST_REFUSED = 3'd1,
      ST_PIXEL   = 3'd2,
      ST_NONE    = 3'd3,
      ST_END     = 3'd4,
      ST_ERROR   = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,      // wait for a beat
      S_DECODE,    // extract one code from the bit buffer
      S_FIRST,     // walk prefix chain for first character
      S_FIRST_W,   // wait for table read
      S_ADD,       // write new dictionary entry
      S_PUSH,      // walk chain of the code, pushing suffixes
      S_PUSH_W,    // wait for table read
      S_POP,       // read top of stack
      S_POP_W,     // wait for stack read
      S_RESP       // hold the result beat
   } state_type;

   localparam logic CSR_MIN_CODE_SIZE = 1'b0;
   localparam logic CSR_IMAGE_WIDTH   = 1'b1;
endpackage

### rtl/gld_ram.sv
// Generic single-port synchronous RAM with registered read.
module gld_ram #(
   parameter int Width = 8,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

### rtl/gif_lzw_decoder.sv
// Top level: GIF LZW decoder, byte in / pixel out, dictionary and stack in RAM.
//
// channel | dir | contents
// req_*   | in  | tdata[0] operation, tdata[8:1] data_byte
// rsp_*   | out | tdata[2:0] status, [10:3] pixel, [11] row_end
// csr_*   | in  | index 0 min_code_size, index 1 image_width
//
// One beat at a time. A padding drain, a length byte or a refused byte goes straight
// from idle to the result; each code decoded makes one dictionary read per chain step
// of its string (twice when the first character must be found), and a pop adds a
// stack read. Reset is synchronous; memories are not cleared. A stalled
// result holds in the output register, and no new beat is taken until it goes.
module gif_lzw_decoder
   import gld_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [0] operation, [8:1] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] status, [10:3] pixel, [11] row_end
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   state_type state_ff, state_in;

   logic [3:0]  mcs_ff, mcs_in;
   logic [15:0] width_ff, width_in;
   logic [12:0] stack_count_ff, stack_count_in;
   logic [19:0] buf_ff, buf_in;
   logic [4:0]  held_ff, held_in;
   logic [3:0]  cw_ff, cw_in;
   logic [12:0] nfc_ff, nfc_in;
   logic [12:0] prev_ff, prev_in;
   logic [7:0]  blk_ff, blk_in;
   logic [15:0] col_ff, col_in;
   logic [1:0]  pad_ff, pad_in;
   logic [1:0]  fin_ff, fin_in;
   logic        drain_ff, drain_in;
   logic [12:0] code_ff, code_in;
   logic [12:0] walk_ff, walk_in;
   logic [7:0]  first_ff, first_in;
   logic [2:0]  rst_ff, rst_in;
   logic [7:0]  rpix_ff, rpix_in;
   logic        rend_ff, rend_in;

   // memory ports
   logic             dict_we, stk_we;
   logic [AddrW-1:0] dict_addr, stk_addr;
   logic [11:0]      pre_wdata, pre_rdata;
   logic [7:0]       suf_wdata, suf_rdata, stk_wdata, stk_rdata;

   gld_ram #(.Width(12), .Depth(MaxCodes)) u_prefix (
      .clock, .we(dict_we), .addr(dict_addr), .wdata(pre_wdata), .rdata(pre_rdata));
   gld_ram #(.Width(8), .Depth(MaxCodes)) u_suffix (
      .clock, .we(dict_we), .addr(dict_addr), .wdata(suf_wdata), .rdata(suf_rdata));
   gld_ram #(.Width(8), .Depth(MaxCodes)) u_stack (
      .clock, .we(stk_we), .addr(stk_addr), .wdata(stk_wdata), .rdata(stk_rdata));

   logic [12:0] clr;
   logic [12:0] cur_code;
   logic        walk_more;
   logic [3:0]  csr_mcs;

   assign clr      = 13'd1 << mcs_ff;
   assign cur_code = 13'(buf_ff & ((20'd1 << cw_ff) - 20'd1));
   assign walk_more = (walk_ff >= clr) && (walk_ff < 13'(MaxCodes));
   assign csr_mcs  = (csr_wdata[3:0] < 4'd2) ? 4'd2 :
                     (csr_wdata[3:0] > 4'd8) ? 4'd8 : csr_wdata[3:0];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {4'd0, rend_ff, rpix_ff, rst_ff};

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      mcs_in = mcs_ff; width_in = width_ff; stack_count_in = stack_count_ff;
      buf_in = buf_ff; held_in = held_ff; cw_in = cw_ff; nfc_in = nfc_ff;
      prev_in = prev_ff; blk_in = blk_ff; col_in = col_ff; pad_in = pad_ff;
      fin_in = fin_ff; drain_in = drain_ff; code_in = code_ff; walk_in = walk_ff;
      first_in = first_ff; rst_in = rst_ff; rpix_in = rpix_ff; rend_in = rend_ff;
      dict_we = 1'b0; stk_we = 1'b0;
      dict_addr = walk_ff[AddrW-1:0]; stk_addr = stack_count_ff[AddrW-1:0];
      pre_wdata = prev_ff[11:0]; suf_wdata = first_ff; stk_wdata = suf_rdata;
      case (state_ff)
         S_IDLE: begin
            if (csr_we) begin
               if (csr_index == CSR_MIN_CODE_SIZE) begin
                  mcs_in  = csr_mcs;
                  cw_in   = csr_mcs + 4'd1;
                  nfc_in  = (13'd1 << csr_mcs) + 13'd2;
                  prev_in = PrevNone;
               end else begin
                  width_in = csr_wdata;
               end
            end
            if (req_tvalid) begin
               rst_in = ST_ACCEPT; rpix_in = 8'd0; rend_in = 1'b0;
               state_in = S_RESP;
               if (!req_tdata[0]) begin
                  drain_in = 1'b0;
                  if (fin_ff != 2'd0 || stack_count_ff != 13'd0 ||
                      held_ff >= {1'b0, cw_ff}) begin
                     rst_in = ST_REFUSED;
                  end else if (blk_ff == 8'd0) begin
                     blk_in = req_tdata[8:1];
                  end else begin
                     blk_in  = blk_ff - 8'd1;
                     buf_in  = buf_ff | (20'(req_tdata[8:1]) << held_ff);
                     held_in = held_ff + 5'd8;
                     state_in = S_DECODE;
                  end
               end else begin
                  drain_in = 1'b1;
                  if (pad_ff != 2'd0) begin
                     pad_in  = pad_ff - 2'd1;
                     rst_in  = ST_PIXEL;
                     rend_in = (pad_ff == 2'd1);
                  end else if (stack_count_ff != 13'd0) begin
                     state_in = S_POP;
                  end else begin
                     state_in = S_DECODE;
                  end
               end
            end
         end
         S_DECODE: begin
            if (fin_ff != 2'd0 || stack_count_ff != 13'd0 ||
                held_ff < {1'b0, cw_ff}) begin
               if (drain_ff) begin
                  state_in = (stack_count_ff != 13'd0) ? S_POP : S_RESP;
                  if (stack_count_ff == 13'd0) rst_in = ST_NONE;
               end else begin
                  state_in = S_RESP;
               end
            end else begin
               buf_in  = buf_ff >> cw_ff;
               held_in = held_ff - {1'b0, cw_ff};
               code_in = cur_code;
               if (cur_code == clr) begin
                  cw_in   = mcs_ff + 4'd1;
                  nfc_in  = clr + 13'd2;
                  prev_in = PrevNone;
               end else if (cur_code == clr + 13'd1) begin
                  fin_in = 2'd1; rst_in = ST_END; state_in = S_RESP;
               end else if (cur_code > nfc_ff || cur_code >= 13'(MaxCodes) ||
                            (cur_code == nfc_ff && prev_ff == PrevNone)) begin
                  fin_in = 2'd2; rst_in = ST_ERROR; state_in = S_RESP;
               end else if (prev_ff != PrevNone) begin
                  walk_in  = (cur_code < nfc_ff) ? cur_code : prev_ff;
                  state_in = S_FIRST;
               end else begin
                  walk_in  = cur_code;
                  state_in = S_PUSH;
               end
            end
         end
         S_FIRST: begin
            if (walk_more) begin
               state_in = S_FIRST_W;
            end else begin
               first_in = walk_ff[7:0];
               state_in = S_ADD;
            end
         end
         S_FIRST_W: begin
            walk_in  = {1'b0, pre_rdata};
            state_in = S_FIRST;
         end
         S_ADD: begin
            if (nfc_ff < 13'(MaxCodes)) begin
               dict_we   = 1'b1;
               dict_addr = nfc_ff[AddrW-1:0];
               nfc_in    = nfc_ff + 13'd1;
               if (nfc_ff + 13'd1 == (13'd1 << cw_ff) && cw_ff < 4'(MaxCodeBits))
                  cw_in = cw_ff + 4'd1;
            end
            walk_in  = code_ff;
            state_in = S_PUSH;
         end
         S_PUSH: begin
            if (walk_more && stack_count_ff < 13'(MaxCodes)) begin
               state_in = S_PUSH_W;
            end else begin
               if (stack_count_ff < 13'(MaxCodes)) begin
                  stk_we = 1'b1;
                  stk_wdata = walk_ff[7:0];
                  stack_count_in = stack_count_ff + 13'd1;
               end
               prev_in  = code_ff;
               state_in = S_DECODE;
            end
         end
         S_PUSH_W: begin
            stk_we = 1'b1;
            stk_wdata = suf_rdata;
            stack_count_in = stack_count_ff + 13'd1;
            walk_in  = {1'b0, pre_rdata};
            state_in = S_PUSH;
         end
         S_POP: begin
            stack_count_in = stack_count_ff - 13'd1;
            stk_addr = stack_count_in[AddrW-1:0];
            state_in = S_POP_W;
         end
         S_POP_W: begin
            rpix_in = stk_rdata;
            rst_in  = ST_PIXEL;
            col_in  = col_ff + 16'd1;
            if (col_ff + 16'd1 == width_ff) begin
               col_in  = 16'd0;
               pad_in  = 2'd0 - width_ff[1:0];
               rend_in = (width_ff[1:0] == 2'd0);
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mcs_ff <= 4'd8; width_ff <= 16'd1; stack_count_ff <= '0;
         buf_ff <= '0; held_ff <= '0; cw_ff <= 4'd9; nfc_ff <= 13'd258;
         prev_ff <= PrevNone; blk_ff <= '0; col_ff <= '0; pad_ff <= '0;
         fin_ff <= '0;
      end else begin
         state_ff <= state_in;
         mcs_ff <= mcs_in; width_ff <= width_in; stack_count_ff <= stack_count_in;
         buf_ff <= buf_in; held_ff <= held_in; cw_ff <= cw_in; nfc_ff <= nfc_in;
         prev_ff <= prev_in; blk_ff <= blk_in; col_ff <= col_in; pad_ff <= pad_in;
         fin_ff <= fin_in;
      end
      drain_ff <= drain_in; code_ff <= code_in; walk_ff <= walk_in;
      first_ff <= first_in; rst_ff <= rst_in; rpix_ff <= rpix_in; rend_ff <= rend_in;
   end
endmodule

### rtl/gld_checker.sv
// Port checker for the GIF LZW decoder, bound to the top level.
module gld_checker
   import gld_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   // one beat in flight: no input taken while a result waits
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while result pending");
   // a held result keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   // status codes stay in range
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= ST_ERROR) else $error("bad status");
   // row end only with a pixel
   a_rend: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11] |-> rsp_tdata[2:0] == ST_PIXEL)
      else $error("row end without pixel");
endmodule

bind gif_lzw_decoder gld_checker u_gld_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata);
